// ===== sv/tstg_pkg.sv =====
// Shared types, constants and the note period table of the tone generator.
`default_nettype none
package tstg_pkg;

  localparam int unsigned NOTE_W    = 3;
  localparam int unsigned SHAPE_W   = 2;
  localparam int unsigned AMP_W     = 13;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PERIOD_W  = 7;
  localparam int unsigned HALF_W    = 6;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned MAG_W     = 6;
  // |level| * amplitude * 4 stays below 2^21
  localparam int unsigned PROD_W    = 21;
  localparam int unsigned MD_CNT_W  = 5;

  localparam logic [NOTE_W-1:0]  NOTE_SILENT    = 3'd7;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [AMP_W-1:0]   AMP_RESET      = 13'd8191;

  localparam logic REG_SHAPE = 1'b0;
  localparam logic REG_AMP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_JOB,
    ST_CALC,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

  // Work handed from the oscillator to the sequencer after one tick
  typedef struct packed {
    logic                 tri_wave;
    logic [SAMPLE_W-1:0]  sample;
    logic [MAG_W-1:0]     mag;
    logic                 neg;
    logic [HALF_W-1:0]    half;
  } tstg_job_t;

  // floor(46875 / f) for C through B
  function automatic logic [PERIOD_W-1:0] note_period(input logic [NOTE_W-1:0] note);
    logic [PERIOD_W-1:0] p;
    case (note)
      3'd0:    p = 7'd89;
      3'd1:    p = 7'd79;
      3'd2:    p = 7'd71;
      3'd3:    p = 7'd67;
      3'd4:    p = 7'd59;
      3'd5:    p = 7'd53;
      3'd6:    p = 7'd47;
      default: p = 7'd47;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/square_triangle_tone_generator.sv =====
// Top level of the square / triangle tone generator: channels, registers, sequencer.
//
// Usage:
//   in_*  : one transfer per audio sample tick; in_tdata[2:0] is the note
//           (0..6 = C..B, 7 = silent).
//   out_* : one transfer per input transfer; out_tdata is the signed
//           16-bit sample for that tick.
//   cfg_* : APB-style register port. Address 0 wave_shape (0 square,
//           1 triangle, 2/3 no sound), address 4 amplitude (13 bits).
//           Write registers only while the block is idle.
// Flow: square, silent and no-sound ticks pass from ST_JOB to ST_DONE
//   and then to out_tvalid. A triangle tick runs the bit-serial unit:
//   a shift-add multiply, then a restoring divide. A new tick is accepted
//   only once the current one has been loaded into the output register.
// Stall: the result sits in the output register until taken; the next
//   item is accepted meanwhile and waits finished in ST_DONE if the
//   output register is still full.
// Reset (rst_n low, synchronous): wave_shape 0, amplitude 8191, square
//   counter 0 on the negative half, triangle level 0 rising, no output.
`default_nettype none
module square_triangle_tone_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [2:0] note_code, [7:3] zero
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // [15:0] sample
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  tstg_pkg::ctl_state_t              state_r, state_nxt;
  logic [tstg_pkg::SHAPE_W-1:0]      shape_r, shape_nxt;
  logic [tstg_pkg::AMP_W-1:0]        amp_r, amp_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [tstg_pkg::SAMPLE_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic [tstg_pkg::SAMPLE_W-1:0]     res_r, res_nxt;

  logic                              in_xfer;
  logic                              cfg_wr;
  logic                              md_start;
  logic                              md_done;
  logic [tstg_pkg::SAMPLE_W-1:0]     md_result;
  tstg_pkg::tstg_job_t               job;

  assign in_tready  = (state_r == tstg_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // register file: the index is address bit 2, low bits ignored
  always_comb begin
    shape_nxt = shape_r;
    amp_nxt   = amp_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == tstg_pkg::REG_SHAPE) begin
        shape_nxt = cfg_pwdata[tstg_pkg::SHAPE_W-1:0];
      end else begin
        amp_nxt = cfg_pwdata[tstg_pkg::AMP_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == tstg_pkg::REG_AMP)
                    ? {{(32-tstg_pkg::AMP_W){1'b0}}, amp_r}
                    : {{(32-tstg_pkg::SHAPE_W){1'b0}}, shape_r};

  // oscillator state advances on the accepting edge
  tstg_osc u_osc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_xfer),
    .note  (in_tdata[tstg_pkg::NOTE_W-1:0]),
    .shape (shape_r),
    .amp   (amp_r),
    .job_r (job)
  );

  tstg_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .mag    (job.mag),
    .amp    (amp_r),
    .half   (job.half),
    .neg    (job.neg),
    .done_r (md_done),
    .result (md_result)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    md_start       = 1'b0;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    // drop the held result once the receiver takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      tstg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = tstg_pkg::ST_JOB;
        end
      end
      tstg_pkg::ST_JOB: begin
        if (job.tri_wave) begin
          md_start  = 1'b1;
          state_nxt = tstg_pkg::ST_CALC;
        end else begin
          res_nxt   = job.sample;
          state_nxt = tstg_pkg::ST_DONE;
        end
      end
      tstg_pkg::ST_CALC: begin
        if (md_done) begin
          res_nxt   = md_result;
          state_nxt = tstg_pkg::ST_DONE;
        end
      end
      tstg_pkg::ST_DONE: begin
        // hold until the output register is free, then load it
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = tstg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tstg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tstg_pkg::ST_IDLE;
      shape_r      <= tstg_pkg::SHAPE_SQUARE;
      amp_r        <= tstg_pkg::AMP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      shape_r      <= shape_nxt;
      amp_r        <= amp_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    res_r       <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/tstg_osc.sv =====
// Oscillator state: square counter and polarity, triangle level and direction.
`default_nettype none
module tstg_osc (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [tstg_pkg::NOTE_W-1:0]    note,
  input  wire logic [tstg_pkg::SHAPE_W-1:0]   shape,
  input  wire logic [tstg_pkg::AMP_W-1:0]     amp,
  output tstg_pkg::tstg_job_t                 job_r
);

  logic [tstg_pkg::PERIOD_W-1:0] sq_count_r, sq_count_nxt;
  logic                          sq_high_r, sq_high_nxt;
  logic signed [tstg_pkg::LEVEL_W-1:0] tri_level_r, tri_level_nxt;
  logic                          tri_rising_r, tri_rising_nxt;
  tstg_pkg::tstg_job_t           job_nxt;

  logic [tstg_pkg::PERIOD_W-1:0] period;
  logic [tstg_pkg::HALF_W-1:0]   half;
  logic signed [7:0]             half_s;
  logic signed [7:0]             lv;
  logic                          pass;
  logic [tstg_pkg::SAMPLE_W-1:0] amp_ext;
  logic                          audible;

  always_comb begin
    period  = tstg_pkg::note_period(note);
    half    = period[tstg_pkg::PERIOD_W-1:1];
    half_s  = signed'({2'b00, half});
    amp_ext = {{(tstg_pkg::SAMPLE_W-tstg_pkg::AMP_W){1'b0}}, amp};
    audible = (note != tstg_pkg::NOTE_SILENT);

    sq_count_nxt   = sq_count_r;
    sq_high_nxt    = sq_high_r;
    tri_level_nxt  = tri_level_r;
    tri_rising_nxt = tri_rising_r;

    job_nxt          = '0;
    job_nxt.half     = half;

    pass = (sq_count_r >= period);
    lv   = 8'(tri_level_r);

    if (step && audible && shape == tstg_pkg::SHAPE_SQUARE) begin
      // compare, then advance; restart and flip on a pass
      sq_count_nxt = pass ? '0 : sq_count_r + 7'd1;
      sq_high_nxt  = pass ? ~sq_high_r : sq_high_r;
      job_nxt.sample = sq_high_nxt ? amp_ext : 16'(~amp_ext + 16'd1);
    end else if (step && audible && shape == tstg_pkg::SHAPE_TRIANGLE) begin
      if (tri_rising_r) begin
        lv = 8'(tri_level_r) + 8'sd1;
        if (lv >= half_s) begin
          lv = half_s;
          tri_rising_nxt = 1'b0;
        end
      end else begin
        lv = 8'(tri_level_r) - 8'sd1;
        if (lv <= -half_s) begin
          lv = -half_s;
          tri_rising_nxt = 1'b1;
        end
      end
      tri_level_nxt    = lv[tstg_pkg::LEVEL_W-1:0];
      job_nxt.tri_wave = 1'b1;
      job_nxt.neg      = lv[7];
      job_nxt.mag      = lv[7] ? 6'(-lv) : lv[tstg_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_count_r   <= '0;
      sq_high_r    <= 1'b0;
      tri_level_r  <= '0;
      tri_rising_r <= 1'b1;
    end else begin
      sq_count_r   <= sq_count_nxt;
      sq_high_r    <= sq_high_nxt;
      tri_level_r  <= tri_level_nxt;
      tri_rising_r <= tri_rising_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tstg_muldiv.sv =====
// Bit-serial shift-add multiply followed by restoring division for the triangle sample.
`default_nettype none
module tstg_muldiv (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [tstg_pkg::MAG_W-1:0]       mag,
  input  wire logic [tstg_pkg::AMP_W-1:0]       amp,
  input  wire logic [tstg_pkg::HALF_W-1:0]      half,
  input  wire logic                             neg,
  output logic                                  done_r,
  output logic [tstg_pkg::SAMPLE_W-1:0]         result
);

  localparam logic [tstg_pkg::MD_CNT_W-1:0] MUL_LAST = tstg_pkg::MD_CNT_W'(tstg_pkg::MAG_W - 1);
  localparam logic [tstg_pkg::MD_CNT_W-1:0] DIV_LAST = tstg_pkg::MD_CNT_W'(tstg_pkg::PROD_W - 1);

  tstg_pkg::md_phase_t             phase_r, phase_nxt;
  logic [tstg_pkg::MD_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            done_nxt;
  logic [tstg_pkg::PROD_W-1:0]     acc_r, acc_nxt;
  logic [tstg_pkg::PROD_W-1:0]     mcand_r, mcand_nxt;
  logic [tstg_pkg::MAG_W-1:0]      mplier_r, mplier_nxt;
  logic [tstg_pkg::HALF_W-1:0]     rem_r, rem_nxt;
  logic [tstg_pkg::HALF_W-1:0]     half_r, half_nxt;
  logic [tstg_pkg::SAMPLE_W-1:0]   quo_r, quo_nxt;
  logic                            neg_r, neg_nxt;
  logic [tstg_pkg::HALF_W:0]       trial;
  logic [tstg_pkg::HALF_W:0]       diff;
  logic                            ge;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    half_nxt   = half_r;
    quo_nxt    = quo_r;
    neg_nxt    = neg_r;

    trial = {rem_r, acc_r[tstg_pkg::PROD_W-1]};
    diff  = trial - {1'b0, half_r};
    ge    = (trial >= {1'b0, half_r});

    case (phase_r)
      tstg_pkg::MD_IDLE: begin
        if (start) begin
          acc_nxt    = '0;
          mcand_nxt  = {{(tstg_pkg::PROD_W-tstg_pkg::AMP_W-2){1'b0}}, amp, 2'b00};
          mplier_nxt = mag;
          half_nxt   = half;
          neg_nxt    = neg;
          rem_nxt    = '0;
          quo_nxt    = '0;
          cnt_nxt    = '0;
          phase_nxt  = tstg_pkg::MD_MUL;
        end
      end
      tstg_pkg::MD_MUL: begin
        // add the shifted multiplicand for each set multiplier bit
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[tstg_pkg::PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[tstg_pkg::MAG_W-1:1]};
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          phase_nxt = tstg_pkg::MD_DIV;
        end
      end
      tstg_pkg::MD_DIV: begin
        // one quotient bit per cycle, numerator shifted out MSB first
        rem_nxt = ge ? diff[tstg_pkg::HALF_W-1:0] : trial[tstg_pkg::HALF_W-1:0];
        acc_nxt = {acc_r[tstg_pkg::PROD_W-2:0], 1'b0};
        quo_nxt = {quo_r[tstg_pkg::SAMPLE_W-2:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          done_nxt  = 1'b1;
          phase_nxt = tstg_pkg::MD_IDLE;
        end
      end
      default: begin
        phase_nxt = tstg_pkg::MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tstg_pkg::MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    half_r   <= half_nxt;
    quo_r    <= quo_nxt;
    neg_r    <= neg_nxt;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign result = neg_r ? 16'(~quo_r + 16'd1) : quo_r;

endmodule
`default_nettype wire
